>>> sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 32;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    localparam logic [DATA_W-1:0] UNDERFLOW_DATA = '1;

    typedef struct packed
    {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none

module spq_cell
(
    input  wire logic                             clk,
    input  wire spq_pkg::cell_cmd_t               cmd,
    input  wire logic                             occupied,
    input  wire logic                             upstream_keep,
    input  wire logic signed [spq_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] left_prio,
    input  wire logic signed [spq_pkg::DATA_W-1:0] right_data,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] right_prio,
    output logic                                  keep,
    output logic signed [spq_pkg::DATA_W-1:0]     data_q,
    output logic signed [spq_pkg::PRIO_W-1:0]     prio_q
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic signed [PRIO_W-1:0] prio_reg;
    logic signed [PRIO_W-1:0] prio_next;

    assign keep   = occupied && (prio_reg >= cmd.prio);
    assign data_q = data_reg;
    assign prio_q = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                if (upstream_keep)
                begin
                    data_next = cmd.data;
                    prio_next = cmd.prio;
                end
                else
                begin
                    data_next = left_data;
                    prio_next = left_prio;
                end
            end
        end
        else if (cmd.deq)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

`default_nettype wire

>>> sv/spq_ctrl.sv
`default_nettype none

module spq_ctrl
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             command,
    input  wire logic signed [spq_pkg::DATA_W-1:0] data,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] priority_req,
    input  wire logic signed [spq_pkg::DATA_W-1:0] head_data,
    output spq_pkg::cell_cmd_t                    cell_cmd,
    output logic [spq_pkg::CNT_W-1:0]             fill,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]     data_out,
    output logic [1:0]                            status,
    output logic [spq_pkg::CNT_W-1:0]             count,
    output logic                                  empty_res,
    output logic                                  full_res
);
    import spq_pkg::*;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] data_out_reg;
    logic signed [DATA_W-1:0] data_out_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [CNT_W-1:0]         res_count_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign cell_cmd.enq  = accept && (command == CMD_ENQ) && !is_full;
    assign cell_cmd.deq  = accept && (command == CMD_DEQ) && !is_empty;
    assign cell_cmd.data = data;
    assign cell_cmd.prio = priority_req;

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_out_next  = data_out_reg;
        status_next    = status_reg;
        if (cell_cmd.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cell_cmd.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (command == CMD_ENQ)
            begin
                data_out_next = '0;
                status_next   = is_full ? ST_OVERFLOW : ST_OK;
            end
            else
            begin
                data_out_next = is_empty ? $signed(UNDERFLOW_DATA) : head_data;
                status_next   = is_empty ? ST_UNDERFLOW : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        if (accept)
        begin
            res_count_reg <= count_next;
        end
    end

    assign fill      = count_reg;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign count     = res_count_reg;
    assign empty_res = (res_count_reg == '0);
    assign full_res  = (res_count_reg == CNT_W'(DEPTH));

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_cmd.enq && cell_cmd.deq))
        else $error("enqueue and dequeue in one cycle");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.enq |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not advance count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OVERFLOW) |-> full_res)
        else $error("overflow reported on a queue that is not full");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_count_reg == count_reg)
        else $error("result count differs from fill count");
`endif

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue_core.sv
// Sorted priority queue of spq_pkg::DEPTH entries, a data word and a signed
// priority each, highest priority at the head, ties served first in first out.
// Input channel (in_valid/in_stall): command 0 enqueues data with priority_req,
// command 1 dequeues the head. Output channel (out_valid/out_stall): one
// result beat per command with data_out, status, count, empty_res, full_res.
// The entries sit in a chain of cells; on every beat each cell compares its
// priority with the broadcast one and holds, takes the new entry, or takes
// its neighbor's entry. Throughput is one beat per cycle while the receiver
// does not stall, set by that single compare-and-shift step of the chain; the
// result appears in the output register the cycle after the beat is taken.
// A refused enqueue on a full queue reports overflow and data_out 0; a dequeue
// on an empty queue reports underflow and data_out -1; neither changes state.
// Reset empties the queue and drops any pending result; no clearing pass runs.
// While the receiver stalls a pending result, in_stall is raised and the
// result holds until taken; the next beat is accepted in the cycle it leaves.
`default_nettype none

module sorted_priority_queue_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             command,
    input  wire logic signed [spq_pkg::DATA_W-1:0] data,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] priority_req,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]     data_out,
    output logic [1:0]                            status,
    output logic [spq_pkg::CNT_W-1:0]             count,
    output logic                                  empty_res,
    output logic                                  full_res
);
    import spq_pkg::*;

    cell_cmd_t                cell_cmd;
    logic [CNT_W-1:0]         fill;
    logic                     keep   [DEPTH];
    logic signed [DATA_W-1:0] data_q [DEPTH];
    logic signed [PRIO_W-1:0] prio_q [DEPTH];

    spq_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data         (data),
        .priority_req (priority_req),
        .head_data    (data_q[0]),
        .cell_cmd     (cell_cmd),
        .fill         (fill),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_out     (data_out),
        .status       (status),
        .count        (count),
        .empty_res    (empty_res),
        .full_res     (full_res)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     up_keep;
        logic signed [DATA_W-1:0] l_data;
        logic signed [PRIO_W-1:0] l_prio;
        logic signed [DATA_W-1:0] r_data;
        logic signed [PRIO_W-1:0] r_prio;

        if (i == 0)
        begin : g_first
            assign up_keep = 1'b1;
            assign l_data  = '0;
            assign l_prio  = '0;
        end
        else
        begin : g_mid
            assign up_keep = keep[i-1];
            assign l_data  = data_q[i-1];
            assign l_prio  = prio_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data = data_q[i];
            assign r_prio = prio_q[i];
        end
        else
        begin : g_inner
            assign r_data = data_q[i+1];
            assign r_prio = prio_q[i+1];
        end

        spq_cell u_cell
        (
            .clk           (clk),
            .cmd           (cell_cmd),
            .occupied      (fill > CNT_W'(i)),
            .upstream_keep (up_keep),
            .left_data     (l_data),
            .left_prio     (l_prio),
            .right_data    (r_data),
            .right_prio    (r_prio),
            .keep          (keep[i]),
            .data_q        (data_q[i]),
            .prio_q        (prio_q[i])
        );
    end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef struct
    {
        logic signed [DATA_W-1:0] data_out;
        status_t                  status;
        logic [CNT_W-1:0]         count;
        logic                     empty_res;
        logic                     full_res;
    } queue_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     command = 1'b0;
    logic signed [DATA_W-1:0] data = '0;
    logic signed [PRIO_W-1:0] priority_req = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;

    logic signed [DATA_W-1:0] model_data [DEPTH];
    logic signed [PRIO_W-1:0] model_prio [DEPTH];
    int unsigned              model_fill = 0;
    queue_result_t            pending_results [$];

    int unsigned error_count = 0;
    int unsigned beats_sent = 0;
    int unsigned results_seen = 0;
    int unsigned enq_count = 0;
    int unsigned deq_count = 0;
    int unsigned overflow_count = 0;
    int unsigned underflow_count = 0;
    int unsigned peak_fill = 0;

    bit          in_idle = 1'b1;
    bit          out_idle = 1'b1;
    int unsigned stall_left = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;

    sorted_priority_queue_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data         (data),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_out     (data_out),
        .status       (status),
        .count        (count),
        .empty_res    (empty_res),
        .full_res     (full_res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic queue_result_t apply_command(input cmd_t cmd,
                                                    input logic signed [DATA_W-1:0] d,
                                                    input logic signed [PRIO_W-1:0] p);
        queue_result_t r;
        int unsigned   slot;
        r.data_out = '0;
        r.status   = ST_OK;
        if (cmd == CMD_ENQ)
        begin
            enq_count++;
            if (model_fill >= DEPTH)
            begin
                r.status = ST_OVERFLOW;
                overflow_count++;
            end
            else
            begin
                slot = model_fill;
                while (slot > 0 && model_prio[slot-1] < p)
                begin
                    model_data[slot] = model_data[slot-1];
                    model_prio[slot] = model_prio[slot-1];
                    slot--;
                end
                model_data[slot] = d;
                model_prio[slot] = p;
                model_fill++;
                if (model_fill > peak_fill)
                    peak_fill = model_fill;
            end
        end
        else
        begin
            deq_count++;
            if (model_fill == 0)
            begin
                r.status   = ST_UNDERFLOW;
                r.data_out = UNDERFLOW_DATA;
                underflow_count++;
            end
            else
            begin
                r.data_out = model_data[0];
                for (slot = 0; slot + 1 < model_fill; slot++)
                begin
                    model_data[slot] = model_data[slot+1];
                    model_prio[slot] = model_prio[slot+1];
                end
                model_fill--;
            end
        end
        r.count     = CNT_W'(model_fill);
        r.empty_res = (model_fill == 0);
        r.full_res  = (model_fill == DEPTH);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] expv,
                                        input logic signed [63:0] actv);
        if (actv !== expv)
        begin
            error_count++;
            if (error_count <= 100)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
        end
    endfunction

    // check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 100)
                    $display("%0t: result beat with no command pending, data_out %0d",
                             $time, data_out);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("data_out", want.data_out, data_out);
                check_field("status", want.status, status);
                check_field("count", want.count, count);
                check_field("empty_res", want.empty_res, empty_res);
                check_field("full_res", want.full_res, full_res);
            end
            stall_left = out_idle ? $urandom_range(0, 7) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid === 1'b1 && stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_beat(input cmd_t cmd, input logic signed [DATA_W-1:0] d,
                             input logic signed [PRIO_W-1:0] p);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        data         <= d;
        priority_req <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(apply_command(cmd, d, p));
        beats_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_beat(input int unsigned enq_pct);
        logic signed [PRIO_W-1:0] p;
        cmd_t                     cmd;
        case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 6) - 3;
            1: p = $urandom();
            2: p = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: p = $urandom_range(0, 40);
        endcase
        cmd = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_DEQ;
        send_beat(cmd, $urandom(), p);
    endtask

    task automatic test_empty_dequeue();
        send_beat(CMD_DEQ, $urandom(), $urandom());
        send_beat(CMD_DEQ, $urandom(), $urandom());
    endtask

    task automatic test_field_extremes();
        send_beat(CMD_ENQ, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_beat(CMD_ENQ, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_beat(CMD_ENQ, 32'sh0000_0000, 32'sh0000_0000);
        send_beat(CMD_ENQ, -32'sd1, -32'sd1);
        send_beat(CMD_ENQ, $urandom(), 32'sh7FFF_FFFF);
        repeat (6)
            send_beat(CMD_DEQ, $urandom(), $urandom());
    endtask

    task automatic test_equal_priority_order();
        send_beat(CMD_ENQ, 32'sd1, 32'sd5);
        send_beat(CMD_ENQ, 32'sd2, 32'sd5);
        send_beat(CMD_ENQ, 32'sd3, 32'sd6);
        send_beat(CMD_ENQ, 32'sd4, 32'sd5);
        send_beat(CMD_ENQ, 32'sd5, 32'sd6);
        repeat (5)
            send_beat(CMD_DEQ, $urandom(), $urandom());
    endtask

    task automatic test_full_queue();
        repeat (DEPTH + 3)
            random_beat(100);
        repeat (DEPTH + 2)
            random_beat(0);
    endtask

    task automatic test_receiver_hold();
        wait_drain();
        in_idle      = 1'b0;
        hold_request = 60;
        repeat (12)
            random_beat(60);
        in_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (20)
            random_beat(65);
        wait_drain();
        repeat (20)
            random_beat(45);
    endtask

    task automatic test_random_mix();
        int unsigned pct;
        repeat (9)
        begin
            case ($urandom_range(0, 2))
                0: pct = 80;
                1: pct = 50;
                default: pct = 25;
            endcase
            in_idle  = $urandom_range(0, 1);
            out_idle = $urandom_range(0, 1);
            repeat (30)
                random_beat(pct);
        end
        in_idle  = 1'b1;
        out_idle = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_dequeue();
        test_field_extremes();
        test_equal_priority_order();
        test_full_queue();
        test_receiver_hold();
        test_drain_pause();
        test_random_mix();

        wait_drain();
        repeat (4) @(negedge clk);
        $display("Ran %0d commands (%0d enqueues, %0d dequeues), %0d results checked,",
                 beats_sent, enq_count, deq_count, results_seen);
        $display("with %0d overflows, %0d underflows and a peak fill of %0d entries.",
                 overflow_count, underflow_count, peak_fill);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[sorted_priority_queue_core] OK");
        else
            $display("[sorted_priority_queue_core] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still pending", pending_results.size());
        $display("[sorted_priority_queue_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue_core.sv
tb/sv/testbench.sv
